@@ rtl/text_to_int64_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the text to int64 parser unit
// Shared wrappers for the concurrent checks of the parser RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INT64_PARSER_UNIT_ASSERT_SVH
`define TEXT_TO_INT64_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTOI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TTOI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("parser assertion failed");

`endif

@@ rtl/ttoi_pkg.sv @@
// ----------------------------------------------------------------------------
// Text to int64 parser package
// Types and character codes shared by the parser modules.
// ----------------------------------------------------------------------------
package ttoi_pkg;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_ZERO   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_DIGITS = 3'd3,
        PH_TRAIL  = 3'd4,
        PH_BAD    = 3'd5
    } t_phase;

    typedef struct packed {
        t_phase             phase;
        logic [VALUE_W-1:0] acc;
        logic               neg;
        logic               hex;
    } t_parse_state;

    localparam t_parse_state PARSE_STATE_RESET = '{
        phase: PH_SKIP,
        acc:   '0,
        neg:   1'b0,
        hex:   1'b0
    };

endpackage

@@ rtl/ttoi_step.sv @@
// ----------------------------------------------------------------------------
// Parser step
// Combinational update of the parse state for one character, with the
// result value and well-formed flag for a terminating zero byte.
// ----------------------------------------------------------------------------
module ttoi_step
    import ttoi_pkg::*;
(
    input  t_parse_state               i_state,
    input  logic [CHAR_W-1:0]          i_ch,
    output t_parse_state               o_state,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic                       o_ok
);

    logic               blank;
    logic               dig_ok;
    logic [DIGIT_W-1:0] dig;
    logic [VALUE_W-1:0] scaled;
    t_parse_state       body;

    always_comb begin
        blank = (i_ch == CH_SPACE) || (i_ch == CH_TAB);

        dig_ok = 1'b0;
        dig    = '0;
        if (i_ch >= CH_ZERO && i_ch <= CH_NINE) begin
            dig_ok = 1'b1;
            dig    = DIGIT_W'(i_ch - CH_ZERO);
        end else if (i_state.hex && i_ch >= CH_A_LO && i_ch <= CH_F_LO) begin
            dig_ok = 1'b1;
            dig    = DIGIT_W'(i_ch - CH_A_LO + 8'd10);
        end else if (i_state.hex && i_ch >= CH_A_UP && i_ch <= CH_F_UP) begin
            dig_ok = 1'b1;
            dig    = DIGIT_W'(i_ch - CH_A_UP + 8'd10);
        end

        if (i_state.hex) begin
            scaled = {i_state.acc[VALUE_W-5:0], 4'b0000};
        end else begin
            scaled = {i_state.acc[VALUE_W-4:0], 3'b000}
                   + {i_state.acc[VALUE_W-2:0], 1'b0};
        end

        body = i_state;
        if (blank) begin
            body.phase = PH_TRAIL;
        end else if (!dig_ok) begin
            body.phase = PH_BAD;
        end else begin
            body.acc   = scaled + VALUE_W'(dig);
            body.phase = PH_DIGITS;
        end

        o_value = i_state.neg ? signed'(VALUE_W'(0) - i_state.acc)
                              : signed'(i_state.acc);
        o_ok    = (i_state.phase == PH_ZERO) || (i_state.phase == PH_DIGITS)
               || (i_state.phase == PH_TRAIL);

        o_state = i_state;
        if (i_ch == CH_NUL) begin
            o_state = PARSE_STATE_RESET;
        end else begin
            case (i_state.phase)
                PH_ZERO: begin
                    if (i_ch == CH_X_LO || i_ch == CH_X_UP) begin
                        o_state.hex   = 1'b1;
                        o_state.phase = PH_PREFIX;
                    end else begin
                        o_state = body;
                    end
                end
                PH_PREFIX, PH_DIGITS: begin
                    o_state = body;
                end
                PH_TRAIL: begin
                    if (!blank) begin
                        o_state.phase = PH_BAD;
                    end
                end
                PH_BAD: begin
                    o_state = i_state;
                end
                default: begin
                    if (blank) begin
                        o_state.phase = PH_SKIP;
                    end else if (i_ch == CH_ZERO) begin
                        o_state.phase = PH_ZERO;
                    end else if (i_ch == CH_PLUS) begin
                        o_state.phase = PH_PREFIX;
                    end else if (i_ch == CH_MINUS) begin
                        o_state.neg   = 1'b1;
                        o_state.phase = PH_PREFIX;
                    end else begin
                        o_state = body;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/text_to_int64_parser_unit.sv @@
// ----------------------------------------------------------------------------
// Text to int64 parser unit
// Streaming parser of blank-padded decimal or 0x-prefixed hexadecimal text
// into a signed 64-bit value with a well-formed flag.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (i_valid, o_stall, i_ch) carries
// one character; a zero byte ends the string. Only the terminator yields a
// request on the output channel (o_valid, i_stall, o_value, o_ok), which
// carries the signed value and the well-formed flag.
// Result: a terminator in the input register is passed into the result
// register, which drives o_valid, o_value and o_ok, once that register is free.
// Throughput: one character per cycle, unless a terminator waits on a full,
// stalled result register. The input register feeds a single pass of
// shift-add logic (multiply by 10 or 16) into the parse state.
// Stall: a held result does not block plain characters; they keep flowing
// into the state. Only a terminator waits in the input register while the
// result register is full and stalled, and then o_stall is raised.
// Reset: synchronous and active low; it empties both registers and returns
// the parse state to skipping leading blanks with a zero accumulator.
// ----------------------------------------------------------------------------
module text_to_int64_parser_unit
    import ttoi_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [CHAR_W-1:0]         i_ch,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_ok
);

    logic                      r_in_valid;
    logic [CHAR_W-1:0]         r_in_ch;
    t_parse_state              r_state;
    t_parse_state              n_state;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_value;
    logic                      r_out_ok;
    logic signed [VALUE_W-1:0] step_value;
    logic                      step_ok;
    logic                      in_term;
    logic                      term_ready;
    logic                      term_taken;
    logic                      state_idle;
    logic                      out_free;
    logic                      consume;

    ttoi_step u_step (
        .i_state (r_state),
        .i_ch    (r_in_ch),
        .o_state (n_state),
        .o_value (step_value),
        .o_ok    (step_ok)
    );

    assign in_term    = r_in_ch == CH_NUL;
    assign term_ready = r_in_valid && in_term;
    assign out_free   = !r_out_valid || !i_stall;
    assign consume    = r_in_valid && (!in_term || out_free);
    assign term_taken = consume && in_term;
    assign state_idle = r_state == PARSE_STATE_RESET;
    assign o_stall    = term_ready && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_STATE_RESET;
        end else if (consume) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= term_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && term_taken) begin
            r_out_value <= step_value;
            r_out_ok    <= step_ok;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_ok    = r_out_ok;

`include "text_to_int64_parser_unit_assert.svh"

    `TTOI_ASSERT_NEXT(a_term_gives_result, i_clk, i_rst_n, term_taken, r_out_valid)
    `TTOI_ASSERT_NEXT(a_term_clears_state, i_clk, i_rst_n, term_taken, state_idle)
    `TTOI_ASSERT_NEXT(a_char_no_result, i_clk, i_rst_n, !r_out_valid && !term_taken, !r_out_valid)
    `TTOI_ASSERT_NOW(a_stall_only_on_term, i_clk, i_rst_n, o_stall, term_ready && r_out_valid)

endmodule
